### rtl/ehe_pkg.sv
// ----------------------------------------------------------------------------
// ehe_pkg
// Shared types, codes and helpers for the EBML element header encoder.
// ----------------------------------------------------------------------------
package ehe_pkg;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_UINT    = 2'd0,  // class ID, length byte, unsigned value
    FUNC_HDR     = 2'd1,  // class ID, vint payload length
    FUNC_UNKNOWN = 2'd2,  // class ID, unknown-size marker
    FUNC_NONE    = 2'd3   // no output
  } ehe_func_t;

  localparam logic [63:0] EHE_VINT_MAX     = 64'h00FF_FFFF_FFFF_FFFE;
  localparam logic [63:0] EHE_UNKNOWN_SIZE = 64'h01FF_FFFF_FFFF_FFFF;
  localparam logic [7:0]  EHE_LEN_MARK     = 8'h80;
  localparam logic [3:0]  EHE_MAX_BYTES    = 4'd8;

  // Depth of the queue between front and back (power of two)
  localparam int EHE_QDEPTH = 2;

  // One work item for the serializer
  typedef struct packed {
    logic        err;       // single error beat
    logic [31:0] id;
    logic [2:0]  id_len;    // 0..4, 0 for an error beat
    logic        pre_en;    // length byte present
    logic [7:0]  pre_byte;
    logic [63:0] body;
    logic [3:0]  body_len;  // 0..8
  } ehe_desc_t;

  // Minimal byte count of a 64-bit value, 1..8
  function automatic logic [3:0] min_bytes64(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (|(v >> (8 * i))) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Minimal byte count of a 32-bit value, 1..4
  function automatic logic [2:0] min_bytes32(input logic [31:0] v);
    logic [2:0] n;
    n = 3'd1;
    for (int i = 1; i < 4; i++) begin
      if (|(v >> (8 * i))) n = 3'(i + 1);
    end
    return n;
  endfunction

  // Vint byte count: smallest L with v <= 2^(7L) - 2, capped at 8
  function automatic logic [3:0] vint_len(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (v > ((64'd1 << (7 * i)) - 64'd2)) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

### rtl/ehe_front.sv
// ----------------------------------------------------------------------------
// ehe_front
// Classifies an input item into a serializer descriptor.
// ----------------------------------------------------------------------------
module ehe_front (
  input  logic [1:0]         func_i,
  input  logic [31:0]        class_id_i,
  input  logic [63:0]        value_i,
  input  logic [3:0]         value_len_i,
  output logic               push_o,
  output ehe_pkg::ehe_desc_t desc_o
);

  ehe_pkg::ehe_func_t func;
  logic [3:0]         n_uint;
  logic [3:0]         n_vint;
  logic [5:0]         mark_sh;

  assign func    = ehe_pkg::ehe_func_t'(func_i);
  assign n_vint  = ehe_pkg::vint_len(value_i);
  assign mark_sh = 6'(n_vint) * 6'd7;

  always_comb begin
    if (value_len_i == 4'd0) begin
      n_uint = ehe_pkg::min_bytes64(value_i);
    end else if (value_len_i > ehe_pkg::EHE_MAX_BYTES) begin
      n_uint = ehe_pkg::EHE_MAX_BYTES;
    end else begin
      n_uint = value_len_i;
    end
  end

  always_comb begin
    push_o          = 1'b1;
    desc_o.err      = 1'b0;
    desc_o.id       = class_id_i;
    desc_o.id_len   = ehe_pkg::min_bytes32(class_id_i);
    desc_o.pre_en   = 1'b0;
    desc_o.pre_byte = ehe_pkg::EHE_LEN_MARK | {4'h0, n_uint};
    desc_o.body     = value_i;
    desc_o.body_len = n_uint;
    case (func)
      ehe_pkg::FUNC_UINT: begin
        desc_o.pre_en = 1'b1;
      end
      ehe_pkg::FUNC_HDR: begin
        if (value_i > ehe_pkg::EHE_VINT_MAX) begin
          desc_o.err      = 1'b1;
          desc_o.id_len   = 3'd0;
          desc_o.body_len = 4'd0;
        end else begin
          desc_o.body     = value_i | (64'd1 << mark_sh);
          desc_o.body_len = n_vint;
        end
      end
      ehe_pkg::FUNC_UNKNOWN: begin
        desc_o.body     = ehe_pkg::EHE_UNKNOWN_SIZE;
        desc_o.body_len = ehe_pkg::EHE_MAX_BYTES;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/ehe_queue.sv
// ----------------------------------------------------------------------------
// ehe_queue
// Short descriptor queue decoupling front and back.
// ----------------------------------------------------------------------------
module ehe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  ehe_pkg::ehe_desc_t wdata_i,
  input  logic               pop_i,
  output ehe_pkg::ehe_desc_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int PW = (ehe_pkg::EHE_QDEPTH > 1) ? $clog2(ehe_pkg::EHE_QDEPTH) : 1;
  localparam int CW = $clog2(ehe_pkg::EHE_QDEPTH + 1);

  ehe_pkg::ehe_desc_t mem_r [ehe_pkg::EHE_QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full_o  = (cnt_r == CW'(ehe_pkg::EHE_QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign rdata_o = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

endmodule

### rtl/ehe_back.sv
// ----------------------------------------------------------------------------
// ehe_back
// Serializer: descriptor into output register, one byte per cycle unless held.
// ----------------------------------------------------------------------------
module ehe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty_i,
  input  ehe_pkg::ehe_desc_t q_desc_i,
  output logic               q_pop_o,
  output logic               busy_o,
  output logic               out_empty_o,
  input  logic               out_pop_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic               out_error_o
);

  logic       busy_r, busy_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r;
  logic       olast_r, oerr_r;

  logic [31:0] id_r;
  logic [2:0]  id_cnt_r, id_cnt_nxt;
  logic        pre_r, pre_nxt;
  logic [7:0]  pre_byte_r;
  logic [63:0] body_r;
  logic [3:0]  body_cnt_r, body_cnt_nxt;
  logic        err_r;

  logic        out_ready, step, load;
  logic [1:0]  id_idx;
  logic [2:0]  body_idx;
  logic [7:0]  emit_byte;
  logic        emit_last;

  assign out_ready = !ovalid_r || out_pop_i;
  assign step      = busy_r && out_ready;
  assign id_idx    = 2'(id_cnt_r - 3'd1);
  assign body_idx  = 3'(body_cnt_r - 4'd1);

  // Current beat
  always_comb begin
    emit_byte    = 8'h00;
    emit_last    = 1'b1;
    id_cnt_nxt   = id_cnt_r;
    pre_nxt      = pre_r;
    body_cnt_nxt = body_cnt_r;
    if (err_r) begin
      emit_byte = 8'h00;
      emit_last = 1'b1;
    end else if (id_cnt_r != 3'd0) begin
      emit_byte  = id_r[{id_idx, 3'b000} +: 8];
      emit_last  = (id_cnt_r == 3'd1) && !pre_r && (body_cnt_r == 4'd0);
      id_cnt_nxt = id_cnt_r - 3'd1;
    end else if (pre_r) begin
      emit_byte = pre_byte_r;
      emit_last = (body_cnt_r == 4'd0);
      pre_nxt   = 1'b0;
    end else begin
      emit_byte    = body_r[{body_idx, 3'b000} +: 8];
      emit_last    = (body_cnt_r <= 4'd1);
      body_cnt_nxt = body_cnt_r - 4'd1;
    end
  end

  // Fetch a new descriptor when idle, or as the current one finishes
  always_comb begin
    load     = !q_empty_i && (!busy_r || (step && emit_last));
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (step && emit_last) begin
      busy_nxt = 1'b0;
    end
    if (step) begin
      ovalid_nxt = 1'b1;
    end else if (out_pop_i) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  assign q_pop_o = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      obyte_r <= emit_byte;
      olast_r <= emit_last;
      oerr_r  <= err_r;
    end
    if (load) begin
      id_r       <= q_desc_i.id;
      id_cnt_r   <= q_desc_i.id_len;
      pre_r      <= q_desc_i.pre_en;
      pre_byte_r <= q_desc_i.pre_byte;
      body_r     <= q_desc_i.body;
      body_cnt_r <= q_desc_i.body_len;
      err_r      <= q_desc_i.err;
    end else if (step) begin
      id_cnt_r   <= id_cnt_nxt;
      pre_r      <= pre_nxt;
      body_cnt_r <= body_cnt_nxt;
    end
  end

  assign busy_o      = busy_r;
  assign out_empty_o = !ovalid_r;
  assign out_byte_o  = obyte_r;
  assign out_last_o  = olast_r;
  assign out_error_o = oerr_r;

endmodule

### rtl/ebml_element_header_encoder.sv
// ----------------------------------------------------------------------------
// ebml_element_header_encoder
// Turns one element request into its EBML header byte run, MSB first.
// ----------------------------------------------------------------------------
//
//  channel  ports                                    beat
//  -------  ---------------------------------------  -------------------------
//  input    push/full, in_func, in_class_id,         one element request
//           in_value, in_value_len
//  result   empty/pop, out_byte, out_last,           one byte of the run
//           out_error
//
// The output register delivers one byte per cycle while pop drains it, and a
// request yields 1 to 13 bytes (error: 1; func 0: id 1-4 + 1 + 1-8 bytes).
// Requests enter every cycle until the two-deep descriptor queue fills.
// From idle, a request is queued, then loaded, then its first byte registered.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// A held result (pop low) stalls the serializer only; the front keeps
// accepting into the queue.
//
module ebml_element_header_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_class_id,
  input  logic [63:0] in_value,
  input  logic [3:0]  in_value_len,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_error
);

  ehe_pkg::ehe_desc_t front_desc;
  ehe_pkg::ehe_desc_t q_desc;
  logic               front_push;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               back_busy;

  // Front: combinational classification of the request
  ehe_front u_front (
    .func_i      (in_func),
    .class_id_i  (in_class_id),
    .value_i     (in_value),
    .value_len_i (in_value_len),
    .push_o      (front_push),
    .desc_o      (front_desc)
  );

  // func 3 is accepted but leaves no descriptor
  assign q_push = push && !full && front_push;

  ehe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .wdata_i (front_desc),
    .pop_i   (q_pop),
    .rdata_o (q_desc),
    .full_o  (full),
    .empty_o (q_empty)
  );

  // Back: byte serializer with output register
  ehe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty_i   (q_empty),
    .q_desc_i    (q_desc),
    .q_pop_o     (q_pop),
    .busy_o      (back_busy),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last),
    .out_error_o (out_error)
  );

  // An error beat is a lone zero byte closing its run
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error) |-> (out_last && out_byte == 8'h00))
    else $error("error beat without last or with nonzero byte");

  // An accepted unknown-size request is held in the queue the cycle after it is taken
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && (in_func == ehe_pkg::FUNC_UNKNOWN)) |=> !q_empty)
    else $error("accepted request missing from queue");

  // Nothing queued, nothing running, nothing shown: no beat may appear
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!back_busy && q_empty && empty) |=> empty)
    else $error("result beat with no work pending");

endmodule
